// ===== hdl/mer_pkg.sv =====
package mer_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = 11;
  localparam int OUT_BITS    = COORD_BITS + 2;
  localparam int SQ_W        = 2 * RADIUS_BITS;
  // operands must hold B (2*RADIUS_BITS) and (2x+1)^2 (2*RADIUS_BITS+2)
  localparam int OP_W        = 2 * RADIUS_BITS + 4;
  localparam int PROD_W      = 2 * OP_W;
  localparam int DEC_W       = PROD_W;

  typedef logic [RADIUS_BITS-1:0]     rad_t;
  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [OUT_BITS-1:0] point_t;
  typedef logic [SQ_W-1:0]            sq_t;
  typedef logic [OP_W-1:0]            op_t;
  typedef logic [PROD_W-1:0]          prod_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic   load;
    coord_t cx;
    coord_t cy;
    rad_t   x;
    rad_t   y;
    logic   last;
  } emit_req_t;

endpackage

// ===== hdl/mer_if.sv =====
interface mer_in_if;
  logic            valid;
  logic            ready;
  logic            command;
  mer_pkg::coord_t center_x;
  mer_pkg::coord_t center_y;
  mer_pkg::rad_t   radius_x;
  mer_pkg::rad_t   radius_y;

  modport source (output valid, command, center_x, center_y, radius_x, radius_y,
                  input ready);
  modport sink (input valid, command, center_x, center_y, radius_x, radius_y,
                output ready);
endinterface

interface mer_out_if;
  logic            valid;
  logic            ready;
  mer_pkg::point_t point_x;
  mer_pkg::point_t point_y;
  logic            last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

// ===== hdl/mer_mul.sv =====
module mer_mul (
  input  logic           clk,
  input  mer_pkg::op_t   op_a,
  input  mer_pkg::op_t   op_b,
  output mer_pkg::prod_t prod
);
  import mer_pkg::*;

  prod_t prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_t'(op_a) * prod_t'(op_b);
  end

  assign prod = prod_r;

endmodule

// ===== hdl/mer_core.sv =====
module mer_core (
  input  logic                clk,
  input  logic                rst_n,
  mer_in_if.sink              in_ch,
  input  logic                emit_free,
  output mer_pkg::emit_req_t  emit_req
);
  import mer_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQA, ST_SQB, ST_AB, ST_INIT,
    ST_C1, ST_C2, ST_C3, ST_R1A, ST_R1B,
    ST_I2, ST_I3, ST_I4, ST_I5, ST_I6,
    ST_R2A, ST_R2B, ST_R2C, ST_R2D
  } state_t;

  state_t              state_r, state_nxt;
  logic                active_r, active_nxt;
  logic                region_two_r, region_two_nxt;
  logic                neg_r, neg_nxt;
  rad_t                x_r, x_nxt;
  rad_t                y_r, y_nxt;
  rad_t                ra_r, ra_nxt;
  rad_t                rb_r, rb_nxt;
  coord_t              cx_r, cx_nxt;
  coord_t              cy_r, cy_nxt;
  sq_t                 a2_r, a2_nxt;
  sq_t                 b2_r, b2_nxt;
  logic [DEC_W-1:0]    dec_r, dec_nxt;
  prod_t               tmp_r, tmp_nxt;

  op_t                 op_a;
  op_t                 op_b;
  prod_t               p;
  logic                in_acc;

  logic [RADIUS_BITS:0]   xp1;
  logic [RADIUS_BITS:0]   y2m1;
  logic [RADIUS_BITS:0]   y2m2;
  logic [RADIUS_BITS+1:0] x2p1;
  logic [RADIUS_BITS+1:0] x2p2;
  logic [RADIUS_BITS+1:0] x2p3;
  rad_t                   ym1;

  mer_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (p)
  );

  assign in_ch.ready = (state_r == ST_IDLE) && emit_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign emit_req.load = in_acc && (in_ch.command == CMD_STEP) && active_r;
  assign emit_req.cx   = cx_r;
  assign emit_req.cy   = cy_r;
  assign emit_req.x    = x_r;
  assign emit_req.y    = y_r;
  assign emit_req.last = (y_r == '0);

  assign xp1  = (RADIUS_BITS+1)'(x_r) + (RADIUS_BITS+1)'(1);
  assign y2m1 = {y_r, 1'b0} - (RADIUS_BITS+1)'(1);
  assign y2m2 = {y_r, 1'b0} - (RADIUS_BITS+1)'(2);
  assign x2p1 = (RADIUS_BITS+2)'({x_r, 1'b0}) + (RADIUS_BITS+2)'(1);
  assign x2p2 = (RADIUS_BITS+2)'({x_r, 1'b0}) + (RADIUS_BITS+2)'(2);
  assign x2p3 = (RADIUS_BITS+2)'({x_r, 1'b0}) + (RADIUS_BITS+2)'(3);
  assign ym1  = y_r - RADIUS_BITS'(1);

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    region_two_nxt = region_two_r;
    neg_nxt        = neg_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    ra_nxt         = ra_r;
    rb_nxt         = rb_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    a2_nxt         = a2_r;
    b2_nxt         = b2_r;
    dec_nxt        = dec_r;
    tmp_nxt        = tmp_r;
    op_a           = '0;
    op_b           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == CMD_START) begin
            cx_nxt         = in_ch.center_x;
            cy_nxt         = in_ch.center_y;
            ra_nxt         = in_ch.radius_x;
            rb_nxt         = in_ch.radius_y;
            x_nxt          = '0;
            y_nxt          = in_ch.radius_y;
            region_two_nxt = 1'b0;
            active_nxt     = 1'b1;
            state_nxt      = ST_SQA;
          end else if (active_r) begin
            if (y_r == '0) begin
              active_nxt = 1'b0;
            end else if (region_two_r) begin
              state_nxt = ST_R2A;
            end else begin
              state_nxt = ST_C1;
            end
          end
        end
      end
      ST_SQA: begin
        op_a      = OP_W'(ra_r);
        op_b      = OP_W'(ra_r);
        state_nxt = ST_SQB;
      end
      ST_SQB: begin
        a2_nxt    = p[SQ_W-1:0];
        op_a      = OP_W'(rb_r);
        op_b      = OP_W'(rb_r);
        state_nxt = ST_AB;
      end
      ST_AB: begin
        // d starts as A + 4B, then 4Ab comes off
        b2_nxt    = p[SQ_W-1:0];
        dec_nxt   = DEC_W'(a2_r) + (p << 2);
        op_a      = OP_W'(a2_r);
        op_b      = OP_W'(rb_r);
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        dec_nxt   = dec_r - (p << 2);
        state_nxt = ST_IDLE;
      end
      ST_C1: begin
        op_a      = OP_W'(a2_r);
        op_b      = OP_W'(y2m1);
        state_nxt = ST_C2;
      end
      ST_C2: begin
        tmp_nxt   = p;
        op_a      = OP_W'(b2_r);
        op_b      = OP_W'(xp1);
        state_nxt = ST_C3;
      end
      ST_C3: begin
        if (tmp_r > (p << 1)) begin
          op_a      = OP_W'(b2_r);
          op_b      = OP_W'(x2p3);
          state_nxt = ST_R1A;
        end else begin
          // switch over to region 2: rebuild d from scratch
          op_a      = OP_W'(x2p1);
          op_b      = OP_W'(x2p1);
          state_nxt = ST_I2;
        end
      end
      ST_R1A: begin
        neg_nxt   = dec_r[DEC_W-1];
        dec_nxt   = dec_r + (p << 2);
        op_a      = OP_W'(a2_r);
        op_b      = OP_W'(y2m2);
        state_nxt = ST_R1B;
      end
      ST_R1B: begin
        if (!neg_r) begin
          dec_nxt = dec_r - (p << 2);
          y_nxt   = ym1;
        end
        x_nxt     = xp1[RADIUS_BITS-1:0];
        state_nxt = ST_IDLE;
      end
      ST_I2: begin
        tmp_nxt   = p;
        op_a      = OP_W'(ym1);
        op_b      = OP_W'(ym1);
        state_nxt = ST_I3;
      end
      ST_I3: begin
        op_a      = OP_W'(b2_r);
        op_b      = tmp_r[OP_W-1:0];
        tmp_nxt   = p;
        state_nxt = ST_I4;
      end
      ST_I4: begin
        dec_nxt   = p;
        op_a      = OP_W'(a2_r);
        op_b      = tmp_r[OP_W-1:0];
        state_nxt = ST_I5;
      end
      ST_I5: begin
        dec_nxt   = dec_r + (p << 2);
        op_a      = OP_W'(a2_r);
        op_b      = OP_W'(b2_r);
        state_nxt = ST_I6;
      end
      ST_I6: begin
        dec_nxt        = dec_r - (p << 2);
        region_two_nxt = 1'b1;
        state_nxt      = ST_R2A;
      end
      ST_R2A: begin
        op_a      = OP_W'(b2_r);
        op_b      = OP_W'(x2p2);
        state_nxt = ST_R2B;
      end
      ST_R2B: begin
        if (dec_r[DEC_W-1]) begin
          dec_nxt = dec_r + (p << 2);
          x_nxt   = xp1[RADIUS_BITS-1:0];
        end
        op_a      = OP_W'(a2_r);
        op_b      = OP_W'(y_r);
        state_nxt = ST_R2C;
      end
      ST_R2C: begin
        dec_nxt   = dec_r - (p << 3);
        y_nxt     = ym1;
        op_a      = OP_W'(a2_r);
        op_b      = OP_W'(12);
        state_nxt = ST_R2D;
      end
      ST_R2D: begin
        dec_nxt   = dec_r + p;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      active_r     <= 1'b0;
      region_two_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      region_two_r <= region_two_nxt;
    end
    neg_r <= neg_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    ra_r  <= ra_nxt;
    rb_r  <= rb_nxt;
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    a2_r  <= a2_nxt;
    b2_r  <= b2_nxt;
    dec_r <= dec_nxt;
    tmp_r <= tmp_nxt;
  end

  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.command == CMD_START) |=> state_r == ST_SQA)
    else $error("start word did not enter squaring sequence");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_req.load |-> emit_free)
    else $error("emitter loaded while busy");

  a_y_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_R2C |=> y_r == $past(ym1))
    else $error("region 2 step did not lower y");

  a_region_switch: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(region_two_r) |-> $past(state_r) == ST_I6)
    else $error("region 2 entered outside its set-up sequence");

endmodule

// ===== hdl/mer_emit.sv =====
module mer_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  mer_pkg::emit_req_t emit_req,
  output logic               emit_free,
  mer_out_if.source          out_ch
);
  import mer_pkg::*;

  logic                busy_r;
  logic [1:0]          cnt_r;
  coord_t              cx_r;
  coord_t              cy_r;
  rad_t                x_r;
  rad_t                y_r;
  logic                last_r;
  logic [OUT_BITS-1:0] px;
  logic [OUT_BITS-1:0] py;

  // word order: (+x,+y) (+x,-y) (-x,+y) (-x,-y)
  assign px = cnt_r[1] ? (OUT_BITS'(cx_r) - OUT_BITS'(x_r))
                       : (OUT_BITS'(cx_r) + OUT_BITS'(x_r));
  assign py = cnt_r[0] ? (OUT_BITS'(cy_r) - OUT_BITS'(y_r))
                       : (OUT_BITS'(cy_r) + OUT_BITS'(y_r));

  assign out_ch.valid      = busy_r;
  assign out_ch.point_x    = point_t'(px);
  assign out_ch.point_y    = point_t'(py);
  assign out_ch.last_point = last_r && (cnt_r == 2'd3);
  assign emit_free         = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (emit_req.load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (out_ch.valid && out_ch.ready) begin
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_r <= 1'b0;
      end
    end
    if (emit_req.load) begin
      cx_r   <= emit_req.cx;
      cy_r   <= emit_req.cy;
      x_r    <= emit_req.x;
      y_r    <= emit_req.y;
      last_r <= emit_req.last;
    end
  end

endmodule

// ===== hdl/midpoint_ellipse_rasterizer_top.sv =====
// Midpoint ellipse rasterizer. A start word (command 0) latches the centre and the two
// semi-axes and gives no output; it occupies the block while the squares and the first
// decision value go through the single 24x24 multiplier, whose product is registered.
// Each step word (command 1) after it gives four output words, the quadrant mirrors of
// the current point, the last of them flagged when y has reached 0; a step word while
// no ellipse is active gives nothing. The four words leave from an output stage while
// the sequencer works out the next point in region 1 or region 2, or crosses into
// region 2, one multiply at a time. A new word is taken once the sequencer is idle and
// the four words of the previous step have been taken, so the block does not take a new
// word before it is through with the last; a step word with no active ellipse leaves
// the sequencer idle.
module midpoint_ellipse_rasterizer_top (
  input  logic       clk,
  input  logic       rst_n,
  mer_in_if.sink     in_ch,
  mer_out_if.source  out_ch
);
  import mer_pkg::*;

  emit_req_t emit_req;
  logic      emit_free;

  mer_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .emit_free (emit_free),
    .emit_req  (emit_req)
  );

  mer_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit_req  (emit_req),
    .emit_free (emit_free),
    .out_ch    (out_ch)
  );

endmodule
